// File: rtl/mts_pkg.sv
// Shared types, register map and constants for the melody tone sequencer.
// Used by mts_div, mts_cfg_regs, the core and the bench (mts_ram does not use it); depends on nothing.
package mts_pkg;

	// Table and arithmetic sizes
	localparam int MAX_NOTES_DEF = 128;
	localparam int DIV_NUM_W     = 27;
	localparam int DIV_DEN_W     = 16;
	localparam int DIV_CNT_W     = $clog2(DIV_NUM_W);
	localparam int PROD_W        = 24;

	localparam logic [15:0] DUTY_DENOM   = 16'd150;
	localparam logic [15:0] LEN_MAX      = 16'hFFFF;
	localparam logic [15:0] RELOAD_MAX   = 16'hFFFF;
	localparam logic [15:0] REST_RELOAD  = 16'd4;
	localparam logic [15:0] REST_COMPARE = 16'd1;

	// Opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Register map (word index)
	localparam int          REG_ADDR_W = 4;
	localparam logic [1:0] REG_WHOLE = 2'd0;
	localparam logic [1:0] REG_CLOCK = 2'd1;
	localparam logic [1:0] REG_MLEN  = 2'd2;
	localparam logic [1:0] REG_DUTY  = 2'd3;

	localparam logic [15:0] WHOLE_RST = 16'd1666;
	localparam logic [26:0] CLOCK_RST = 27'd200000;
	localparam logic [7:0]  MLEN_RST  = 8'd99;
	localparam logic [7:0]  DUTY_RST  = 8'd50;

	typedef struct packed {
		logic        opcode;
		logic [6:0]  entry_index;
		logic [15:0] entry_pitch;
		logic signed [7:0] entry_divider;
	} request_t;

	typedef struct packed {
		logic [15:0] reload_value;
		logic [15:0] compare_value;
		logic        note_started;
		logic [6:0]  next_position;
	} result_t;

	typedef struct packed {
		logic [15:0] pitch;
		logic signed [7:0] divider;
	} entry_t;

	typedef struct packed {
		logic [15:0] whole_note_ticks;
		logic [26:0] timer_clock_hz;
		logic [7:0]  melody_length;
		logic [7:0]  duty_numerator;
	} cfg_t;

endpackage

// File: rtl/mts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/mts_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on mts_pkg for operand widths.
module mts_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [mts_pkg::DIV_NUM_W-1:0]  dividend,
	input  logic [mts_pkg::DIV_DEN_W-1:0]  divisor,
	output logic                           done,
	output logic [mts_pkg::DIV_NUM_W-1:0]  quotient
);

	localparam int NW = mts_pkg::DIV_NUM_W;
	localparam int DW = mts_pkg::DIV_DEN_W;
	localparam int CW = mts_pkg::DIV_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		fits  = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// shift dividend out, quotient bit in
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/mts_cfg_regs.sv
// APB-style configuration registers of the melody tone sequencer.
// Depends on mts_pkg for the register map and config struct.
module mts_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mts_pkg::REG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output mts_pkg::cfg_t                   cfg
);

	mts_pkg::cfg_t cfg_q;
	logic [1:0]    reg_idx;
	logic          wr_en;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.whole_note_ticks <= mts_pkg::WHOLE_RST;
			cfg_q.timer_clock_hz   <= mts_pkg::CLOCK_RST;
			cfg_q.melody_length    <= mts_pkg::MLEN_RST;
			cfg_q.duty_numerator   <= mts_pkg::DUTY_RST;
		end else if (wr_en) begin
			case (reg_idx)
				mts_pkg::REG_WHOLE: cfg_q.whole_note_ticks <= pwdata[15:0];
				mts_pkg::REG_CLOCK: cfg_q.timer_clock_hz   <= pwdata[26:0];
				mts_pkg::REG_MLEN:  cfg_q.melody_length    <= pwdata[7:0];
				mts_pkg::REG_DUTY:  cfg_q.duty_numerator   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mts_pkg::REG_WHOLE: prdata = {16'd0, cfg_q.whole_note_ticks};
			mts_pkg::REG_CLOCK: prdata = {5'd0, cfg_q.timer_clock_hz};
			mts_pkg::REG_MLEN:  prdata = {24'd0, cfg_q.melody_length};
			mts_pkg::REG_DUTY:  prdata = {24'd0, cfg_q.duty_numerator};
			default:            prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/melody_tone_sequencer_core.sv
// Melody tone sequencer top level: sequencer around one shared divider.
// Depends on mts_pkg, mts_ram, mts_div and mts_cfg_regs.
//
//  channel   | handshake                         | payload
//  ----------+-----------------------------------+-----------------------------
//  request   | start high while busy low         | request  (mts_pkg::request_t)
//  result    | result_valid, one cycle, no stall | result   (mts_pkg::result_t)
//  config    | psel/penable/pwrite, pready = 1   | paddr, pwdata, prdata
//
// A write request or a tick that starts no note returns its result the cycle after
// acceptance. A tick that starts a note holds busy through the length state, the
// note length divider pass, the tone state, the reload pass, the multiply and
// compare-start states, the compare pass and the result state, which strobes the
// result. A zero divider or a zero pitch skips its pass; both together skip two.
// Reset clears all control state and loads the rest tone; the melody table is not
// cleared and must be written before it is played.
// One request is in flight at a time; the result side cannot stall.
module melody_tone_sequencer_core #(
	parameter int MAX_NOTES = mts_pkg::MAX_NOTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  mts_pkg::request_t               request,
	output logic                            result_valid,
	output mts_pkg::result_t                result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mts_pkg::REG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int AW  = $clog2(MAX_NOTES);
	localparam int NXW = AW + 1;
	localparam int CMW = (NXW > 8) ? NXW : 8;
	localparam int EW  = $bits(mts_pkg::entry_t);
	localparam int NW  = mts_pkg::DIV_NUM_W;
	localparam int DW  = mts_pkg::DIV_DEN_W;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_LEN       = 4'd1;
	localparam logic [3:0] S_LEN_WAIT  = 4'd2;
	localparam logic [3:0] S_TONE      = 4'd3;
	localparam logic [3:0] S_TONE_WAIT = 4'd4;
	localparam logic [3:0] S_MUL       = 4'd5;
	localparam logic [3:0] S_CMP       = 4'd6;
	localparam logic [3:0] S_CMP_WAIT  = 4'd7;
	localparam logic [3:0] S_DONE      = 4'd8;

	mts_pkg::cfg_t   cfg;
	mts_pkg::entry_t entry;
	mts_pkg::entry_t wr_entry;

	logic [3:0]                  state_q;
	logic [AW-1:0]               pos_q;
	logic [15:0]                 elapsed_q;
	logic [15:0]                 len_q;
	logic [15:0]                 reload_q;
	logic [15:0]                 compare_q;
	logic                        started_q;
	logic [mts_pkg::PROD_W-1:0]  product_q;

	logic          accept;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_rdata;
	logic          div_start;
	logic [NW-1:0] div_dividend;
	logic [DW-1:0] div_divisor;
	logic          div_done;
	logic [NW-1:0] div_quotient;
	logic [7:0]    div_mag;
	logic [15:0]   base_len;
	logic [16:0]   dotted_len;
	logic [NXW-1:0] nxt_raw;
	logic [AW-1:0] nxt_pos;

	mts_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign accept = start && !busy;
	assign busy   = state_q != S_IDLE;

	// drop table writes beyond the table depth
	assign ram_we    = accept && (request.opcode == mts_pkg::OP_WRITE)
		&& (int'(request.entry_index) < MAX_NOTES);
	assign ram_waddr = AW'(request.entry_index);
	assign wr_entry.pitch   = request.entry_pitch;
	assign wr_entry.divider = request.entry_divider;

	mts_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_NOTES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	// pos_q holds until the note is done, so the read data stays valid
	assign entry = mts_pkg::entry_t'(ram_rdata);

	assign div_mag = entry.divider[7] ? 8'(-entry.divider) : 8'(entry.divider);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = NW'(product_q);
		div_divisor  = mts_pkg::DUTY_DENOM;
		case (state_q)
			S_LEN: begin
				div_start    = entry.divider != 8'sd0;
				div_dividend = NW'(cfg.whole_note_ticks);
				div_divisor  = DW'(div_mag);
			end
			S_TONE: begin
				div_start    = entry.pitch != 16'd0;
				div_dividend = cfg.timer_clock_hz;
				div_divisor  = entry.pitch;
			end
			S_CMP: begin
				div_start = 1'b1;
			end
			default: ;
		endcase
	end

	mts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_comb begin
		base_len   = div_quotient[15:0];
		dotted_len = {1'b0, base_len} + {2'b0, base_len[15:1]};
		nxt_raw    = NXW'(pos_q) + 1'b1;
		// wrap at melody length or table depth, whichever comes first
		if (CMW'(nxt_raw) >= CMW'(cfg.melody_length) || nxt_raw >= NXW'(MAX_NOTES)) begin
			nxt_pos = '0;
		end else begin
			nxt_pos = AW'(nxt_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pos_q     <= '0;
			elapsed_q <= '0;
			len_q     <= '0;
			reload_q  <= mts_pkg::REST_RELOAD;
			compare_q <= mts_pkg::REST_COMPARE;
			started_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						started_q <= 1'b0;
						state_q   <= S_DONE;
						if (request.opcode == mts_pkg::OP_TICK) begin
							if (elapsed_q >= len_q) begin
								elapsed_q <= '0;
								state_q   <= S_LEN;
							end else begin
								elapsed_q <= elapsed_q + 1'b1;
							end
						end
					end
				end
				S_LEN: begin
					// zero divider keeps the old length
					state_q <= (entry.divider != 8'sd0) ? S_LEN_WAIT : S_TONE;
				end
				S_LEN_WAIT: begin
					if (div_done) begin
						if (!entry.divider[7]) begin
							len_q <= base_len;
						end else if (dotted_len[16]) begin
							len_q <= mts_pkg::LEN_MAX;
						end else begin
							len_q <= dotted_len[15:0];
						end
						state_q <= S_TONE;
					end
				end
				S_TONE: begin
					if (entry.pitch == 16'd0) begin
						reload_q <= mts_pkg::RELOAD_MAX;
						state_q  <= S_MUL;
					end else begin
						state_q <= S_TONE_WAIT;
					end
				end
				S_TONE_WAIT: begin
					if (div_done) begin
						reload_q <= div_quotient[15:0] - 16'd1;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= S_CMP_WAIT;
				end
				S_CMP_WAIT: begin
					if (div_done) begin
						compare_q <= div_quotient[15:0];
						pos_q     <= nxt_pos;
						started_q <= 1'b1;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			product_q <= reload_q * cfg.duty_numerator;
		end
	end

	assign result_valid         = state_q == S_DONE;
	assign result.reload_value  = reload_q;
	assign result.compare_value = compare_q;
	assign result.note_started  = started_q;
	assign result.next_position = 7'(pos_q);

endmodule

// File: bench/tb.sv
// Self-checking bench for melody_tone_sequencer_core: table writes and ticks through
// the start/busy port, settings through the APB port, results checked against a
// cycle-free note predictor. Depends on rtl/mts_pkg.sv and the core RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NOTE_SLOTS     = mts_pkg::MAX_NOTES_DEF;
	localparam int PHASES         = 6;
	localparam int PHASE_ITEMS    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 120;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [1:0]        reg_idx;
		logic [31:0]       reg_val;
		mts_pkg::request_t req;
		bit                checked;
		mts_pkg::result_t  want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	mts_pkg::request_t request = '0;
	logic        result_valid;
	mts_pkg::result_t  result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [mts_pkg::REG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Predicted sequencer state and settings
	logic [15:0]       pitch_tbl [NOTE_SLOTS];
	logic signed [7:0] div_tbl [NOTE_SLOTS];
	bit                slot_written [NOTE_SLOTS];
	logic [6:0]        pred_pos = '0;
	logic [15:0]       pred_elapsed = '0;
	logic [15:0]       pred_len = '0;
	logic [15:0]       pred_reload = mts_pkg::REST_RELOAD;
	logic [15:0]       pred_compare = mts_pkg::REST_COMPARE;
	logic [15:0]       cfg_whole = mts_pkg::WHOLE_RST;
	logic [26:0]       cfg_clock = mts_pkg::CLOCK_RST;
	logic [7:0]        cfg_mlen = mts_pkg::MLEN_RST;
	logic [7:0]        cfg_duty = mts_pkg::DUTY_RST;

	mts_pkg::result_t tone_due [$];
	mts_pkg::result_t due_head;

	int requests_sent = 0;
	int table_writes = 0;
	int note_starts = 0;
	int settings_written = 0;
	int results_seen = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	melody_tone_sequencer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #2 clk = ~clk;

	// One accepted request: update the table or count a tick, maybe begin a note
	function automatic mts_pkg::result_t advance_melody(input mts_pkg::request_t item);
		mts_pkg::result_t res;
		logic [15:0] prior;
		int          dv;
		int          base;
		int          span;
		int          nxt;
		longint      rl;
		res.note_started = 1'b0;
		if (item.opcode == mts_pkg::OP_WRITE) begin
			pitch_tbl[item.entry_index] = item.entry_pitch;
			div_tbl[item.entry_index] = item.entry_divider;
			slot_written[item.entry_index] = 1'b1;
			table_writes++;
		end else begin
			prior = pred_elapsed;
			pred_elapsed = pred_elapsed + 16'd1;
			if (prior >= pred_len) begin
				dv = int'(div_tbl[pred_pos]);
				if (dv < 0) begin
					base = int'(cfg_whole) / (-dv);
					span = base + base / 2;
					pred_len = (span > int'(mts_pkg::LEN_MAX)) ? mts_pkg::LEN_MAX
						: span[15:0];
				end else if (dv > 0) begin
					pred_len = 16'(int'(cfg_whole) / dv);
				end
				if (pitch_tbl[pred_pos] == 16'd0) begin
					rl = 64'hFFFF;
				end else begin
					rl = (longint'(cfg_clock) / longint'(pitch_tbl[pred_pos]) - 1) & 64'hFFFF;
				end
				pred_reload = rl[15:0];
				pred_compare = 16'((rl * longint'(cfg_duty)
					/ longint'(mts_pkg::DUTY_DENOM)) & 64'hFFFF);
				nxt = int'(pred_pos) + 1;
				if (nxt >= int'(cfg_mlen) || nxt >= NOTE_SLOTS) begin
					nxt = 0;
				end
				pred_pos = nxt[6:0];
				pred_elapsed = '0;
				res.note_started = 1'b1;
				note_starts++;
			end
		end
		res.reload_value = pred_reload;
		res.compare_value = pred_compare;
		res.next_position = pred_pos;
		return res;
	endfunction

	function automatic mts_pkg::request_t make_request(input logic op, input int idx,
			input int pitch, input int dv);
		mts_pkg::request_t item;
		item.opcode = op;
		item.entry_index = 7'(idx);
		item.entry_pitch = 16'(pitch);
		item.entry_divider = 8'(dv);
		return item;
	endfunction

	function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.reg_idx = idx;
		row.reg_val = val;
		row.req = '0;
		row.checked = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic stim_row_t req_row(input mts_pkg::request_t item, input bit checked,
			input mts_pkg::result_t want);
		stim_row_t row;
		row.kind = ROW_REQ;
		row.reg_idx = '0;
		row.reg_val = '0;
		row.req = item;
		row.checked = checked;
		row.want = want;
		return row;
	endfunction

	// Hold start until the core takes the request, then record what it should return
	task automatic issue(input mts_pkg::request_t item, input bit checked,
			input mts_pkg::result_t want);
		mts_pkg::result_t guess;
		start <= 1'b1;
		request <= item;
		do @(posedge clk); while (busy);
		guess = advance_melody(item);
		tone_due.push_back(checked ? want : guess);
		requests_sent++;
	endtask

	// Write a setting once every pending result is back
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		start <= 1'b0;
		while (tone_due.size() != 0 || busy) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			mts_pkg::REG_WHOLE: cfg_whole = val[15:0];
			mts_pkg::REG_CLOCK: cfg_clock = val[26:0];
			mts_pkg::REG_MLEN:  cfg_mlen = val[7:0];
			mts_pkg::REG_DUTY:  cfg_duty = val[7:0];
			default: ;
		endcase
		settings_written++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("[%0t] result mismatch: %s", $realtime, what);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			results_seen++;
			if (tone_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result reload=%0d compare=%0d started=%0d pos=%0d",
					result.reload_value, result.compare_value, result.note_started,
					result.next_position));
			end else begin
				due_head = tone_due.pop_front();
				if (result.reload_value !== due_head.reload_value
						|| result.compare_value !== due_head.compare_value
						|| result.note_started !== due_head.note_started
						|| result.next_position !== due_head.next_position) begin
					report_mismatch($sformatf({"expected reload=%0d compare=%0d started=%0d pos=%0d,",
						" got reload=%0d compare=%0d started=%0d pos=%0d"},
						due_head.reload_value, due_head.compare_value, due_head.note_started,
						due_head.next_position, result.reload_value, result.compare_value,
						result.note_started, result.next_position));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] no progress for %0d cycles, %0d results outstanding",
				$realtime, idle_cycles, tone_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		stim_row_t directed_rows [$];
		mts_pkg::request_t item;
		int        idle_pct;
		int        starts_before;
		int        pick;
		foreach (slot_written[i]) begin
			slot_written[i] = 1'b0;
			pitch_tbl[i] = '0;
			div_tbl[i] = '0;
		end

		// Reset state is the rest tone; then ticks walk a short melody
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_WRITE, 0, 0, 1), 1,
			mts_pkg::result_t'{16'd4, 16'd1, 1'b0, 7'd0}));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_WRITE, 127, 65535, -128), 1,
			mts_pkg::result_t'{16'd4, 16'd1, 1'b0, 7'd0}));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_WRITE, 1, 1, 127), 1,
			mts_pkg::result_t'{16'd4, 16'd1, 1'b0, 7'd0}));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_WRITE, 2, 440, -3), 0, '0));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_WRITE, 3, 65535, 0), 0, '0));
		directed_rows.push_back(cfg_row(mts_pkg::REG_WHOLE, 32'd1));
		directed_rows.push_back(cfg_row(mts_pkg::REG_MLEN, 32'd4));
		// zero pitch plays the longest period
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 1,
			mts_pkg::result_t'{16'd65535, 16'd21845, 1'b1, 7'd1}));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 1,
			mts_pkg::result_t'{16'd65535, 16'd21845, 1'b0, 7'd1}));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 0, '0));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 0, '0));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 0, '0));
		// zero clock wraps the reload; duty above full scale masks the compare
		directed_rows.push_back(cfg_row(mts_pkg::REG_CLOCK, 32'd0));
		directed_rows.push_back(cfg_row(mts_pkg::REG_DUTY, 32'd255));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 1,
			mts_pkg::result_t'{16'd65535, 16'd45873, 1'b1, 7'd1}));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 1,
			mts_pkg::result_t'{16'd65535, 16'd45873, 1'b0, 7'd1}));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 1,
			mts_pkg::result_t'{16'd65535, 16'd45873, 1'b1, 7'd2}));
		// melody length zero wraps at once
		directed_rows.push_back(cfg_row(mts_pkg::REG_DUTY, 32'd0));
		directed_rows.push_back(cfg_row(mts_pkg::REG_MLEN, 32'd0));
		directed_rows.push_back(cfg_row(mts_pkg::REG_CLOCK, 32'd1));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 1,
			mts_pkg::result_t'{16'd65535, 16'd0, 1'b1, 7'd0}));
		directed_rows.push_back(cfg_row(mts_pkg::REG_MLEN, 32'd1));
		directed_rows.push_back(cfg_row(mts_pkg::REG_DUTY, 32'd150));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 1,
			mts_pkg::result_t'{16'd65535, 16'd65535, 1'b1, 7'd0}));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 1,
			mts_pkg::result_t'{16'd65535, 16'd65535, 1'b0, 7'd0}));
		// dotted note
		directed_rows.push_back(cfg_row(mts_pkg::REG_MLEN, 32'd255));
		directed_rows.push_back(cfg_row(mts_pkg::REG_CLOCK, 32'd100000000));
		directed_rows.push_back(cfg_row(mts_pkg::REG_WHOLE, 32'd4));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_WRITE, 0, 1000, -1), 0, '0));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 0, '0));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 0, '0));
		directed_rows.push_back(req_row(make_request(mts_pkg::OP_TICK, 0, 0, 0), 0, '0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				issue(directed_rows[i].req, directed_rows[i].checked, directed_rows[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			idle_pct = (ph < 2) ? 18 : (ph < 4) ? 46 : 0;
			pick = $urandom_range(9);
			write_reg(mts_pkg::REG_WHOLE, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1
				: (pick < 7) ? $urandom_range(2, 24) : (pick < 9) ? $urandom_range(25, 400)
				: $urandom_range(401, 1000));
			case ($urandom_range(5))
				0: write_reg(mts_pkg::REG_CLOCK, 32'd0);
				1: write_reg(mts_pkg::REG_CLOCK, 32'd1);
				2: write_reg(mts_pkg::REG_CLOCK, 32'h07FF_FFFF);
				3: write_reg(mts_pkg::REG_CLOCK, 32'd100000000);
				4: write_reg(mts_pkg::REG_CLOCK, $urandom_range(1, 100000000));
				default: write_reg(mts_pkg::REG_CLOCK, $urandom_range(1000, 2000000));
			endcase
			case ($urandom_range(6))
				0: write_reg(mts_pkg::REG_MLEN, 32'd0);
				1: write_reg(mts_pkg::REG_MLEN, 32'd1);
				2: write_reg(mts_pkg::REG_MLEN, 32'd128);
				3: write_reg(mts_pkg::REG_MLEN, 32'd255);
				4: write_reg(mts_pkg::REG_MLEN, $urandom_range(129, 254));
				default: write_reg(mts_pkg::REG_MLEN, $urandom_range(2, 127));
			endcase
			case ($urandom_range(4))
				0: write_reg(mts_pkg::REG_DUTY, 32'd0);
				1: write_reg(mts_pkg::REG_DUTY, 32'd150);
				2: write_reg(mts_pkg::REG_DUTY, $urandom_range(151, 255));
				default: write_reg(mts_pkg::REG_DUTY, $urandom_range(1, 149));
			endcase

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				while ($urandom_range(99) < idle_pct) begin
					start <= 1'b0;
					@(posedge clk);
				end
				if ($urandom_range(99) < 30) begin
					item = make_request(mts_pkg::OP_WRITE, $urandom_range(0, NOTE_SLOTS - 1),
						0, 0);
				end else begin
					item = make_request(mts_pkg::OP_TICK, $urandom, $urandom, $urandom);
				end
				// never let a tick play a slot that holds nothing yet: fill it instead
				if (item.opcode == mts_pkg::OP_TICK && pred_elapsed >= pred_len
						&& !slot_written[pred_pos]) begin
					item.opcode = mts_pkg::OP_WRITE;
					item.entry_index = pred_pos;
				end
				if (item.opcode == mts_pkg::OP_WRITE) begin
					case ($urandom_range(9))
						0: item.entry_pitch = 16'd0;
						1: item.entry_pitch = 16'hFFFF;
						2, 3, 4: item.entry_pitch = 16'($urandom_range(1, 2000));
						default: item.entry_pitch = 16'($urandom);
					endcase
					item.entry_divider = ($urandom_range(9) == 0) ? 8'sd0 : 8'($urandom);
				end
				issue(item, 1'b0, '0);
			end
		end

		// Longest settings last: a saturated dotted note never ends within the run
		write_reg(mts_pkg::REG_WHOLE, 32'd65535);
		write_reg(mts_pkg::REG_CLOCK, 32'h07FF_FFFF);
		issue(make_request(mts_pkg::OP_WRITE, int'(pred_pos), 1, -1), 1'b0, '0);
		do begin
			starts_before = note_starts;
			issue(make_request(mts_pkg::OP_TICK, 0, 0, 0), 1'b0, '0);
		end while (note_starts == starts_before);
		issue(make_request(mts_pkg::OP_WRITE, int'(pred_pos), 65535, 127), 1'b0, '0);
		repeat (3) issue(make_request(mts_pkg::OP_TICK, 0, 0, 0), 1'b0, '0);
		start <= 1'b0;

		while (tone_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d table writes, %0d note starts) across %0d setting writes",
			requests_sent, table_writes, note_starts, settings_written);
		$display("Checked %0d results, %0d mismatched", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/mts_pkg.sv
rtl/mts_ram.sv
rtl/mts_div.sv
rtl/mts_cfg_regs.sv
rtl/melody_tone_sequencer_core.sv
bench/tb.sv
